FILE: design/bplc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias point lock controller package
// Shared widths, codes, register layouts and small helper functions.
// ----------------------------------------------------------------------------
package bplc_pkg;

    localparam int DRIVE_BITS     = 16;
    localparam int SAMPLE_BITS    = 12;
    localparam int COUNT_BITS     = 9;
    localparam int GAIN_BITS      = 8;
    localparam int STEPS_BITS     = 16;
    localparam int PHASE_BITS     = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = DRIVE_BITS;
    localparam int BACK_BITS      = STEPS_BITS + GAIN_BITS;

    localparam logic [DRIVE_BITS-1:0] DRIVE_MAX = {DRIVE_BITS{1'b1}};
    localparam logic [STEPS_BITS-1:0] STEPS_MAX = {STEPS_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_NULL       = 2'd0,
        MODE_QUAD_MINUS = 2'd1,
        MODE_QUAD_PLUS  = 2'd2,
        MODE_PEAK       = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE        = 3'd0,
        REG_SETPOINT    = 3'd1,
        REG_TOLERANCE   = 3'd2,
        REG_PEAK_REV    = 3'd3,
        REG_NULL_REV    = 3'd4,
        REG_GAIN        = 3'd5,
        REG_LOW_FLOOR   = 3'd6,
        REG_START_DRIVE = 3'd7
    } reg_index_t;

    // Loop sequencer state, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_PROBE  = 4'b0010,
        PH_SETTLE = 4'b0100,
        PH_TRACK  = 4'b1000
    } phase_t;

    // Codes reported on the phase output.
    localparam logic [PHASE_BITS-1:0] PHASE_CODE_IDLE   = 2'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_CODE_PROBE  = 2'd1;
    localparam logic [PHASE_BITS-1:0] PHASE_CODE_SETTLE = 2'd2;
    localparam logic [PHASE_BITS-1:0] PHASE_CODE_TRACK  = 2'd3;

    localparam logic [SAMPLE_BITS-1:0] TOLERANCE_RESET = 12'd62;
    localparam logic [COUNT_BITS-1:0]  REVERSAL_RESET  = 9'd50;
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET      = 8'd8;
    localparam logic [SAMPLE_BITS-1:0] LOW_FLOOR_RESET = 12'd12;

    typedef struct packed {
        mode_t                  mode;
        logic [SAMPLE_BITS-1:0] setpoint;
        logic [SAMPLE_BITS-1:0] tolerance;
        logic [COUNT_BITS-1:0]  peak_rev;
        logic [COUNT_BITS-1:0]  null_rev;
        logic [GAIN_BITS-1:0]   gain;
        logic [SAMPLE_BITS-1:0] low_floor;
    } cfg_t;

    typedef struct packed {
        logic [DRIVE_BITS-1:0]  drive;
        phase_t                 phase;
        logic                   climb_right;
        logic [DRIVE_BITS-1:0]  probe_origin;
        logic [STEPS_BITS-1:0]  probe_steps;
        logic [SAMPLE_BITS-1:0] probe_ref;
        logic [SAMPLE_BITS-1:0] last_err;
        logic [SAMPLE_BITS-1:0] ref_err;
        logic [COUNT_BITS-1:0]  growth;
    } loop_state_t;

    typedef struct packed {
        logic [DRIVE_BITS-1:0] drive;
        logic                  locked;
        logic                  edge_hit;
        logic                  low_signal;
        logic [PHASE_BITS-1:0] phase;
    } result_t;

    // One gain step up or down, saturating at the drive limits.
    function automatic logic [DRIVE_BITS-1:0] nudge(
        input logic [DRIVE_BITS-1:0] d,
        input logic [GAIN_BITS-1:0]  g,
        input logic                  up
    );
        logic [DRIVE_BITS:0] sum;
        sum = {1'b0, d} + {{(DRIVE_BITS+1-GAIN_BITS){1'b0}}, g};
        if (up)
            return (sum > {1'b0, DRIVE_MAX}) ? DRIVE_MAX : sum[DRIVE_BITS-1:0];
        else
            return (d > {{(DRIVE_BITS-GAIN_BITS){1'b0}}, g})
                ? d - {{(DRIVE_BITS-GAIN_BITS){1'b0}}, g}
                : '0;
    endfunction

    function automatic logic at_limit(input logic [DRIVE_BITS-1:0] d);
        return (d == '0) || (d == DRIVE_MAX);
    endfunction

    function automatic logic [PHASE_BITS-1:0] phase_code(input phase_t p);
        logic [PHASE_BITS-1:0] code;
        unique case (p)
            PH_IDLE:   code = PHASE_CODE_IDLE;
            PH_PROBE:  code = PHASE_CODE_PROBE;
            PH_SETTLE: code = PHASE_CODE_SETTLE;
            PH_TRACK:  code = PHASE_CODE_TRACK;
            default:   code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: design/bplc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias point lock controller step logic
// Next loop state and result for one sample, in a single combinational pass.
// ----------------------------------------------------------------------------
module bplc_step
    import bplc_pkg::*;
(
    input  cfg_t                   cfg,
    input  loop_state_t            state,
    input  logic [SAMPLE_BITS-1:0] sample,
    output loop_state_t            state_next,
    output result_t                result
);

    logic [SAMPLE_BITS-1:0] err;
    logic                   locked;
    logic                   low;
    logic                   peak;
    logic                   up;
    logic [COUNT_BITS-1:0]  limit;
    logic [COUNT_BITS-1:0]  growth_inc;
    logic [SAMPLE_BITS-1:0] ref_err;
    logic [BACK_BITS-1:0]   back;
    logic [BACK_BITS-1:0]   origin_ext;
    logic [PHASE_BITS-1:0]  ph_code;
    logic                   edge_now;

    assign err = (sample > cfg.setpoint) ? sample - cfg.setpoint : cfg.setpoint - sample;
    assign locked = (err <= cfg.tolerance);
    assign low    = (sample < cfg.low_floor);
    assign peak   = (cfg.mode == MODE_PEAK);
    assign limit  = peak ? cfg.peak_rev : cfg.null_rev;

    // Retreat distance for a probe that saw a rising reading.
    assign back       = state.probe_steps * cfg.gain;
    assign origin_ext = {{(BACK_BITS-DRIVE_BITS){1'b0}}, state.probe_origin};

    // The first growing error of a run latches the reference error.
    assign ref_err    = (state.growth == '0) ? state.last_err : state.ref_err;
    assign growth_inc = (state.growth == COUNT_MAX) ? state.growth : state.growth + 1'b1;

    always_comb
    begin
        state_next = state;
        ph_code    = PHASE_CODE_IDLE;
        up         = 1'b0;

        if (!at_limit(state.drive))
        begin
            if (cfg.mode == MODE_QUAD_MINUS || cfg.mode == MODE_QUAD_PLUS)
            begin
                state_next.phase = PH_IDLE;
                if (!locked)
                begin
                    up = (cfg.mode == MODE_QUAD_MINUS) ? (sample > cfg.setpoint)
                                                       : (sample < cfg.setpoint);
                    state_next.drive = nudge(state.drive, cfg.gain, up);
                    ph_code = PHASE_CODE_TRACK;
                end
            end
            else
            begin
                unique case (state.phase)
                    PH_IDLE:
                    begin
                        if (!locked)
                        begin
                            state_next.probe_origin = state.drive;
                            state_next.probe_ref    = sample;
                            state_next.last_err     = err;
                            state_next.growth       = '0;
                            state_next.probe_steps  = {{(STEPS_BITS-1){1'b0}}, 1'b1};
                            state_next.drive        = nudge(state.drive, cfg.gain, 1'b1);
                            state_next.phase        = PH_PROBE;
                        end
                    end
                    PH_PROBE:
                    begin
                        if (sample == state.probe_ref)
                        begin
                            if (state.probe_steps != STEPS_MAX)
                                state_next.probe_steps = state.probe_steps + 1'b1;
                            state_next.drive = nudge(state.drive, cfg.gain, 1'b1);
                        end
                        else if (sample < state.probe_ref)
                        begin
                            state_next.climb_right = !peak;
                            state_next.drive       = nudge(state.drive, cfg.gain, !peak);
                            state_next.phase       = PH_TRACK;
                        end
                        else
                        begin
                            state_next.climb_right = peak;
                            state_next.drive = (origin_ext > back)
                                ? state.probe_origin - back[DRIVE_BITS-1:0]
                                : '0;
                            state_next.phase = PH_SETTLE;
                        end
                    end
                    PH_SETTLE:
                    begin
                        state_next.drive = nudge(state.drive, cfg.gain, state.climb_right);
                        state_next.phase = PH_TRACK;
                    end
                    PH_TRACK:
                    begin
                        state_next.ref_err = ref_err;
                        if (err > ref_err)
                        begin
                            state_next.growth = growth_inc;
                            if (growth_inc == limit)
                            begin
                                state_next.climb_right = !state.climb_right;
                                state_next.growth      = '0;
                            end
                        end
                        state_next.last_err = err;
                        if (locked)
                            state_next.phase = PH_IDLE;
                        else
                            state_next.drive = nudge(state.drive, cfg.gain,
                                                     state_next.climb_right);
                    end
                    default:
                    begin
                        state_next.phase = PH_IDLE;
                    end
                endcase
                ph_code = phase_code(state_next.phase);
            end
        end

        edge_now = at_limit(state_next.drive);
        if (edge_now)
        begin
            state_next.phase = PH_IDLE;
            ph_code          = PHASE_CODE_IDLE;
        end

        result.drive      = state_next.drive;
        result.locked     = locked;
        result.edge_hit   = edge_now;
        result.low_signal = low;
        result.phase      = ph_code;
    end

endmodule

FILE: design/bias_point_lock_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias point lock controller
// Turns one ADC reading per item into the next drive level and lock status.
// ----------------------------------------------------------------------------
// The block takes one sample item per clock unless the output stalls, and
// returns one result item per sample: the sample is held in an input register,
// the step logic computes the new drive and loop state in one pass, and the
// result lands in an output register. While a result waits on a stalled output,
// one more sample can still enter the input register; only after that does the
// input side stall. After reset the drive is zero, so the loop reports edge_hit
// and holds still until start_drive is written; a drive that reaches zero or
// full scale halts the loop the same way. Write configuration only while no
// item is in flight.
module bias_point_lock_controller
    import bplc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [DRIVE_BITS-1:0]     drive,
    output logic                      locked,
    output logic                      edge_hit,
    output logic                      low_signal,
    output logic [PHASE_BITS-1:0]     phase
);

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    loop_state_t            state_reg;
    loop_state_t            state_next;
    loop_state_t            step_state;
    result_t                step_result;
    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    logic [SAMPLE_BITS-1:0] hold_sample_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_result_reg;
    logic                   out_ready;
    logic                   advance;
    logic                   in_accept;

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = hold_valid_reg && out_ready;
    assign in_stall  = hold_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    bplc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .sample     (hold_sample_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    always_comb
    begin
        cfg_next   = cfg_reg;
        state_next = advance ? step_state : state_reg;
        if (cfg_write_en)
        begin
            state_next = state_reg;
            unique case (reg_index_t'(cfg_index))
                REG_MODE:
                begin
                    cfg_next.mode    = mode_t'(cfg_data[1:0]);
                    state_next.phase = PH_IDLE;
                end
                REG_SETPOINT:    cfg_next.setpoint  = cfg_data[SAMPLE_BITS-1:0];
                REG_TOLERANCE:   cfg_next.tolerance = cfg_data[SAMPLE_BITS-1:0];
                REG_PEAK_REV:    cfg_next.peak_rev  = cfg_data[COUNT_BITS-1:0];
                REG_NULL_REV:    cfg_next.null_rev  = cfg_data[COUNT_BITS-1:0];
                REG_GAIN:        cfg_next.gain      = cfg_data[GAIN_BITS-1:0];
                REG_LOW_FLOOR:   cfg_next.low_floor = cfg_data[SAMPLE_BITS-1:0];
                REG_START_DRIVE:
                begin
                    state_next.drive  = cfg_data[DRIVE_BITS-1:0];
                    state_next.phase  = PH_IDLE;
                    state_next.growth = '0;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_accept)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;

        out_valid_next = out_ready ? advance : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_NULL;
            cfg_reg.setpoint  <= '0;
            cfg_reg.tolerance <= TOLERANCE_RESET;
            cfg_reg.peak_rev  <= REVERSAL_RESET;
            cfg_reg.null_rev  <= REVERSAL_RESET;
            cfg_reg.gain      <= GAIN_RESET;
            cfg_reg.low_floor <= LOW_FLOOR_RESET;
            state_reg.drive        <= '0;
            state_reg.phase        <= PH_IDLE;
            state_reg.climb_right  <= 1'b0;
            state_reg.probe_origin <= '0;
            state_reg.probe_steps  <= '0;
            state_reg.probe_ref    <= '0;
            state_reg.last_err     <= '0;
            state_reg.ref_err      <= '0;
            state_reg.growth       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            hold_sample_reg <= sample;
        if (advance)
            out_result_reg <= step_result;
    end

    assign out_valid  = out_valid_reg;
    assign drive      = out_result_reg.drive;
    assign locked     = out_result_reg.locked;
    assign edge_hit   = out_result_reg.edge_hit;
    assign low_signal = out_result_reg.low_signal;
    assign phase      = out_result_reg.phase;

endmodule

FILE: design/bplc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias point lock controller checker
// Port-level checks on handshake and result consistency.
// ----------------------------------------------------------------------------
module bplc_checker
    import bplc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [DRIVE_BITS-1:0] drive,
    input logic                  edge_hit,
    input logic [PHASE_BITS-1:0] phase
);

    // The input side only backs up when a result is waiting and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output could drain");

    // A stalled result item holds its drive value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(drive)))
        else $error("stalled result item changed or vanished");

    // An edge report means the drive sits at a limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && edge_hit) |-> (drive == '0 || drive == DRIVE_MAX))
        else $error("edge_hit without drive at a limit");

    // A halted loop reports the idle phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && edge_hit) |-> (phase == PHASE_CODE_IDLE))
        else $error("edge_hit with a non-idle phase");

endmodule

bind bias_point_lock_controller bplc_checker u_bplc_checker (.*);

FILE: bench/bias_point_lock_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias point lock controller testbench
// A short scripted sequence covers reset, the drive limits, each mode, the
// slope probe and the hill climb. Random batches follow, each with fresh
// register settings and samples mostly from a simple plant that reacts to the
// drive. Each result must match its typed row or a cycle-free loop predictor.
// ----------------------------------------------------------------------------
module bias_point_lock_controller_test;
    import bplc_pkg::*;

    localparam int RANDOM_ITEMS = 1950;

    typedef enum bit [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        reg_index_t             idx;
        logic [CFG_DATA_BITS-1:0] value;
        logic [SAMPLE_BITS-1:0] s;
        result_t                want;
    } script_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [SAMPLE_BITS-1:0]    sample;
    logic                      out_valid;
    logic                      out_stall;
    logic [DRIVE_BITS-1:0]     drive;
    logic                      locked;
    logic                      edge_hit;
    logic                      low_signal;
    logic [PHASE_BITS-1:0]     phase;

    bias_point_lock_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive        (drive),
        .locked       (locked),
        .edge_hit     (edge_hit),
        .low_signal   (low_signal),
        .phase        (phase)
    );

    // Predicted register settings.
    mode_t                  cur_mode     = MODE_NULL;
    logic [SAMPLE_BITS-1:0] cur_setpoint = '0;
    logic [SAMPLE_BITS-1:0] cur_tol      = TOLERANCE_RESET;
    logic [COUNT_BITS-1:0]  cur_peak_rev = REVERSAL_RESET;
    logic [COUNT_BITS-1:0]  cur_null_rev = REVERSAL_RESET;
    logic [GAIN_BITS-1:0]   cur_gain     = GAIN_RESET;
    logic [SAMPLE_BITS-1:0] cur_floor    = LOW_FLOOR_RESET;

    // Predicted loop state.
    logic [DRIVE_BITS-1:0]  lvl         = '0;
    logic [PHASE_BITS-1:0]  loop_ph     = PHASE_CODE_IDLE;
    logic                   climb_up    = 1'b0;
    logic [DRIVE_BITS-1:0]  probe_base  = '0;
    logic [STEPS_BITS-1:0]  probe_count = '0;
    logic [SAMPLE_BITS-1:0] probe_ref   = '0;
    logic [SAMPLE_BITS-1:0] last_err    = '0;
    logic [SAMPLE_BITS-1:0] ref_err     = '0;
    logic [COUNT_BITS-1:0]  grow_cnt    = '0;

    // Plant used to turn the current drive into the next reading.
    int unsigned plant_center;
    int unsigned plant_shift;
    int unsigned plant_top;
    int unsigned plant_shape;
    int unsigned plant_noise;

    result_t     due_results[$];
    script_row_t script[$];
    result_t     seen;
    result_t     want;

    int unsigned send_pct;
    int unsigned stall_pct;
    int unsigned fault_count;
    int unsigned shown_count;
    int unsigned result_count;
    int unsigned sent_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [DRIVE_BITS-1:0] step_drive(
        input logic [DRIVE_BITS-1:0] d,
        input logic                  up
    );
        int unsigned t;
        if (up)
        begin
            t = d + cur_gain;
            return (t > DRIVE_MAX) ? DRIVE_MAX : DRIVE_BITS'(t);
        end
        return (d > cur_gain) ? d - cur_gain : '0;
    endfunction

    function automatic logic at_end(input logic [DRIVE_BITS-1:0] d);
        return d == '0 || d == DRIVE_MAX;
    endfunction

    // Moves the predicted loop by one sample and returns the result it causes.
    function automatic result_t advance_loop(input logic [SAMPLE_BITS-1:0] s);
        int unsigned           e;
        int unsigned           lim;
        int unsigned           back;
        logic                  lk;
        logic                  pk;
        logic                  up;
        logic [PHASE_BITS-1:0] ph_out;
        result_t               r;
        e = (s > cur_setpoint) ? s - cur_setpoint : cur_setpoint - s;
        lk = e <= cur_tol;
        ph_out = PHASE_CODE_IDLE;
        if (!at_end(lvl))
        begin
            if (cur_mode == MODE_QUAD_MINUS || cur_mode == MODE_QUAD_PLUS)
            begin
                loop_ph = PHASE_CODE_IDLE;
                if (!lk)
                begin
                    up = (cur_mode == MODE_QUAD_MINUS) ? s > cur_setpoint : s < cur_setpoint;
                    lvl = step_drive(lvl, up);
                    ph_out = PHASE_CODE_TRACK;
                end
            end
            else
            begin
                pk = cur_mode == MODE_PEAK;
                lim = pk ? cur_peak_rev : cur_null_rev;
                case (loop_ph)
                    PHASE_CODE_IDLE:
                    begin
                        if (!lk)
                        begin
                            probe_base = lvl;
                            probe_ref = s;
                            last_err = SAMPLE_BITS'(e);
                            grow_cnt = '0;
                            probe_count = STEPS_BITS'(1);
                            lvl = step_drive(lvl, 1'b1);
                            loop_ph = PHASE_CODE_PROBE;
                        end
                    end
                    PHASE_CODE_PROBE:
                    begin
                        if (s == probe_ref)
                        begin
                            if (probe_count < STEPS_MAX)
                                probe_count = probe_count + 1'b1;
                            lvl = step_drive(lvl, 1'b1);
                        end
                        else if (s < probe_ref)
                        begin
                            climb_up = !pk;
                            lvl = step_drive(lvl, climb_up);
                            loop_ph = PHASE_CODE_TRACK;
                        end
                        else
                        begin
                            // A rising reading sends the drive back past its origin.
                            back = probe_count * cur_gain;
                            climb_up = pk;
                            lvl = (probe_base > back) ? DRIVE_BITS'(probe_base - back) : '0;
                            loop_ph = PHASE_CODE_SETTLE;
                        end
                    end
                    PHASE_CODE_SETTLE:
                    begin
                        lvl = step_drive(lvl, climb_up);
                        loop_ph = PHASE_CODE_TRACK;
                    end
                    default:
                    begin
                        if (grow_cnt == 0)
                            ref_err = last_err;
                        if (e > ref_err)
                        begin
                            if (grow_cnt < COUNT_MAX)
                                grow_cnt = grow_cnt + 1'b1;
                            if (grow_cnt == lim)
                            begin
                                climb_up = !climb_up;
                                grow_cnt = '0;
                            end
                        end
                        last_err = SAMPLE_BITS'(e);
                        if (lk)
                            loop_ph = PHASE_CODE_IDLE;
                        else
                            lvl = step_drive(lvl, climb_up);
                    end
                endcase
                ph_out = loop_ph;
            end
        end
        if (at_end(lvl))
        begin
            loop_ph = PHASE_CODE_IDLE;
            ph_out = PHASE_CODE_IDLE;
        end
        r.drive = lvl;
        r.locked = lk;
        r.edge_hit = at_end(lvl);
        r.low_signal = s < cur_floor;
        r.phase = ph_out;
        return r;
    endfunction

    function automatic void apply_reg(
        input reg_index_t               idx,
        input logic [CFG_DATA_BITS-1:0] data
    );
        case (idx)
            REG_MODE:
            begin
                cur_mode = mode_t'(data[1:0]);
                loop_ph = PHASE_CODE_IDLE;
            end
            REG_SETPOINT:    cur_setpoint = data[SAMPLE_BITS-1:0];
            REG_TOLERANCE:   cur_tol = data[SAMPLE_BITS-1:0];
            REG_PEAK_REV:    cur_peak_rev = data[COUNT_BITS-1:0];
            REG_NULL_REV:    cur_null_rev = data[COUNT_BITS-1:0];
            REG_GAIN:        cur_gain = data[GAIN_BITS-1:0];
            REG_LOW_FLOOR:   cur_floor = data[SAMPLE_BITS-1:0];
            REG_START_DRIVE:
            begin
                lvl = data;
                loop_ph = PHASE_CODE_IDLE;
                grow_cnt = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] plant_reading();
        int unsigned d;
        int unsigned span;
        int unsigned v;
        d = lvl;
        span = ((d > plant_center) ? d - plant_center : plant_center - d) >> plant_shift;
        case (plant_shape)
            0:       v = (span >= plant_top) ? 0 : plant_top - span;
            1:       v = plant_top + span;
            2:       v = d >> 4;
            default: v = 4095 - (d >> 4);
        endcase
        v = v + $urandom_range(0, plant_noise);
        if (v > 4095)
            v = 4095;
        return SAMPLE_BITS'(v);
    endfunction

    // Random bits above the register's width must be ignored by the block.
    function automatic logic [CFG_DATA_BITS-1:0] with_junk(
        input int unsigned v,
        input int unsigned mask
    );
        return CFG_DATA_BITS'(($urandom & ~mask) | (v & mask));
    endfunction

    function automatic void row(
        input row_kind_t                k,
        input reg_index_t               idx,
        input logic [CFG_DATA_BITS-1:0] value,
        input logic [SAMPLE_BITS-1:0]   s,
        input result_t                  w
    );
        script_row_t r;
        r.kind = k;
        r.idx = idx;
        r.value = value;
        r.s = s;
        r.want = w;
        script.push_back(r);
    endfunction

    // Entered and left at a falling edge; waits until nothing is in flight.
    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    // Entered and left at a falling edge.
    task automatic offer_sample(
        input logic [SAMPLE_BITS-1:0] s,
        input logic                   typed,
        input result_t                w
    );
        result_t r;
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample = s;
        do
            @(posedge clk);
        while (in_stall);
        r = advance_loop(s);
        due_results.push_back(typed ? w : r);
        sent_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = rst_n && ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            seen.drive = drive;
            seen.locked = locked;
            seen.edge_hit = edge_hit;
            seen.low_signal = low_signal;
            seen.phase = phase;
            if (due_results.size() == 0)
            begin
                fault_count++;
                if (shown_count < 10)
                begin
                    shown_count++;
                    $display("result %0d arrived with nothing outstanding", result_count);
                end
            end
            else
            begin
                want = due_results.pop_front();
                if (seen.drive !== want.drive || seen.locked !== want.locked
                    || seen.edge_hit !== want.edge_hit
                    || seen.low_signal !== want.low_signal
                    || seen.phase !== want.phase)
                begin
                    fault_count++;
                    if (shown_count < 10)
                    begin
                        shown_count++;
                        $display("result %0d: expected drive %0d locked %0b edge %0b low %0b phase %0d",
                                 result_count, want.drive, want.locked, want.edge_hit,
                                 want.low_signal, want.phase);
                        $display("            got      drive %0d locked %0b edge %0b low %0b phase %0d",
                                 seen.drive, seen.locked, seen.edge_hit, seen.low_signal,
                                 seen.phase);
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned batch;
        int unsigned batch_len;
        int unsigned pick;
        int unsigned m;
        int unsigned sp;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample = '0;
        send_pct = 0;
        stall_pct = 0;
        fault_count = 0;
        shown_count = 0;
        result_count = 0;
        sent_count = 0;

        // After reset the drive sits at zero, so the loop reports an edge.
        row(ROW_TYPED, REG_MODE, '0, 12'd0, {16'd0, 1'b1, 1'b1, 1'b1, PHASE_CODE_IDLE});
        row(ROW_TYPED, REG_MODE, '0, 12'd4095, {16'd0, 1'b0, 1'b1, 1'b0, PHASE_CODE_IDLE});
        row(ROW_TYPED, REG_MODE, '0, 12'd62, {16'd0, 1'b1, 1'b1, 1'b0, PHASE_CODE_IDLE});
        // Full scale halts the loop as well.
        row(ROW_WRITE, REG_START_DRIVE, 16'hFFFF, '0, '0);
        row(ROW_TYPED, REG_MODE, '0, 12'd11, {16'hFFFF, 1'b1, 1'b1, 1'b1, PHASE_CODE_IDLE});
        row(ROW_WRITE, REG_LOW_FLOOR, 16'hFFFF, '0, '0);
        row(ROW_TYPED, REG_MODE, '0, 12'd4094, {16'hFFFF, 1'b0, 1'b1, 1'b1, PHASE_CODE_IDLE});
        // Quad plus with the largest gain runs into full scale.
        row(ROW_WRITE, REG_MODE, 16'hFFFE, '0, '0);
        row(ROW_WRITE, REG_SETPOINT, 16'hF7D0, '0, '0);
        row(ROW_WRITE, REG_TOLERANCE, 16'hF000, '0, '0);
        row(ROW_WRITE, REG_GAIN, 16'd255, '0, '0);
        row(ROW_WRITE, REG_LOW_FLOOR, 16'd0, '0, '0);
        row(ROW_WRITE, REG_START_DRIVE, 16'd65000, '0, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd0, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd0, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd0, '0);
        // Quad minus, then a gain of zero that never moves the drive.
        row(ROW_WRITE, REG_MODE, MODE_QUAD_MINUS, '0, '0);
        row(ROW_WRITE, REG_GAIN, 16'd1, '0, '0);
        row(ROW_WRITE, REG_START_DRIVE, 16'd1000, '0, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd4095, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd2000, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd0, '0);
        row(ROW_WRITE, REG_GAIN, 16'd0, '0, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd0, '0);
        // Null mode: probe, rising retreat, settle, climb with reversal after one.
        row(ROW_WRITE, REG_MODE, MODE_NULL, '0, '0);
        row(ROW_WRITE, REG_GAIN, 16'd16, '0, '0);
        row(ROW_WRITE, REG_NULL_REV, 16'hFE01, '0, '0);
        row(ROW_WRITE, REG_START_DRIVE, 16'd30000, '0, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd100, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd100, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd200, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd4000, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd4000, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd3990, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd2000, '0);
        // Peak mode with no reversal: a falling probe, then the climb hits zero.
        row(ROW_WRITE, REG_MODE, MODE_PEAK, '0, '0);
        row(ROW_WRITE, REG_PEAK_REV, 16'd0, '0, '0);
        row(ROW_WRITE, REG_GAIN, 16'd200, '0, '0);
        row(ROW_WRITE, REG_TOLERANCE, 16'd5, '0, '0);
        row(ROW_WRITE, REG_SETPOINT, 16'd4095, '0, '0);
        row(ROW_WRITE, REG_START_DRIVE, 16'd100, '0, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd500, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd400, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd300, '0);
        // A retreat that would pass below zero clamps there.
        row(ROW_WRITE, REG_START_DRIVE, 16'd50, '0, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd1000, '0);
        row(ROW_SAMPLE, REG_MODE, '0, 12'd1100, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
                write_reg(script[i].idx, script[i].value);
            else
                offer_sample(script[i].s, script[i].kind == ROW_TYPED, script[i].want);
        end

        sent_count = 0;
        batch = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            case (batch % 4)
                0:       begin send_pct = 0;  stall_pct = 0;  end
                1:       begin send_pct = 52; stall_pct = 0;  end
                2:       begin send_pct = 0;  stall_pct = 52; end
                default: begin send_pct = 26; stall_pct = 26; end
            endcase

            m = $urandom_range(0, 3);
            plant_center = $urandom_range(0, 65535);
            plant_shift = $urandom_range(2, 6);
            plant_noise = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                plant_shape = $urandom_range(0, 3);
            else if (m == MODE_PEAK)
                plant_shape = 0;
            else if (m == MODE_NULL)
                plant_shape = 1;
            else
                plant_shape = $urandom_range(2, 3);
            plant_top = (plant_shape == 0) ? $urandom_range(200, 4095) : $urandom_range(0, 600);
            if (plant_shape == 0)
                sp = plant_top - $urandom_range(0, 30);
            else if (plant_shape == 1)
                sp = plant_top + $urandom_range(0, 30);
            else
                sp = $urandom_range(0, 4095);

            write_reg(REG_MODE, with_junk(m, 16'h0003));
            write_reg(REG_SETPOINT, with_junk(sp, 16'h0FFF));
            pick = $urandom_range(0, 9);
            write_reg(REG_TOLERANCE, with_junk(pick == 0 ? 0 : pick == 1 ? 4095
                                               : $urandom_range(0, 80), 16'h0FFF));
            pick = $urandom_range(0, 9);
            write_reg(REG_PEAK_REV, with_junk(pick == 0 ? 0 : pick == 1 ? 511 : pick == 2 ? 500
                                              : $urandom_range(1, 10), 16'h01FF));
            pick = $urandom_range(0, 9);
            write_reg(REG_NULL_REV, with_junk(pick == 0 ? 0 : pick == 1 ? 511 : pick == 2 ? 500
                                              : $urandom_range(1, 10), 16'h01FF));
            pick = $urandom_range(0, 19);
            write_reg(REG_GAIN, with_junk(pick == 0 ? 0 : pick == 1 ? 255 : pick == 2 ? 1
                                          : $urandom_range(1, 48), 16'h00FF));
            write_reg(REG_LOW_FLOOR, with_junk($urandom_range(0, 4095), 16'h0FFF));
            pick = $urandom_range(0, 19);
            write_reg(REG_START_DRIVE, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF
                      : pick == 2 ? 16'd1 : pick == 3 ? 16'hFFFE
                      : 16'($urandom_range(1000, 64535)));

            batch_len = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(10, 40);
            repeat (batch_len)
            begin
                if ($urandom_range(0, 4) == 0)
                    offer_sample(12'($urandom_range(0, 4095)), 1'b0, '0);
                else
                    offer_sample(plant_reading(), 1'b0, '0);
            end
            batch++;
        end

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
